>>> rtl/assert_macros.svh
// assertion macros used by the checker file ut2c_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/ut2c_pkg.sv
// shared types, constants and the month table of the epoch to calendar converter
// no dependencies
package ut2c_pkg;

    // total register stages from input to output
    localparam int LATENCY = 7;

    // seconds per day over 128, and floor(2^35 / 675)
    localparam logic [9:0]  DAY_DIV     = 10'd675;
    localparam logic [25:0] DAY_RECIP   = 26'd50903316;
    // seconds per hour over 16, and floor(2^20 / 225)
    localparam logic [7:0]  HOUR_DIV    = 8'd225;
    localparam logic [12:0] HOUR_RECIP  = 13'd4660;
    // seconds per minute over 4, and floor(2^14 / 15)
    localparam logic [3:0]  MIN_DIV     = 4'd15;
    localparam logic [10:0] MIN_RECIP   = 11'd1092;
    // days per four year cycle, and floor(2^26 / 1461)
    localparam logic [10:0] CYCLE_DIV   = 11'd1461;
    localparam logic [15:0] CYCLE_RECIP = 16'd45933;

    // day count of 2100-03-01 from 1970-01-01: from here on 2100 is treated as a leap
    // year whose feb 29 is skipped
    localparam logic [15:0] SKIP_DAY    = 16'd47541;
    // days from 1968-01-01 to 1970-01-01
    localparam logic [15:0] BASE_OFFSET = 16'd731;
    localparam logic [11:0] BASE_YEAR   = 12'd1968;

    typedef struct packed {
        logic [15:0] days;
        logic [16:0] secs;
    } split_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_t;

    // zero based day of year on which a month starts
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] month);
        logic [8:0] base;
        case (month)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + ((leap && (month > 4'd2)) ? 9'd1 : 9'd0);
    endfunction

endpackage

>>> rtl/unix_time_to_calendar.sv
// top level of the epoch seconds to gregorian date and time converter
// depends on ut2c_pkg, ut2c_split, ut2c_clock, ut2c_date
//
//  channel | dir | payload
//  s_      | in  | epoch_seconds (32 bits)
//  m_      | out | cal_year, cal_month, cal_day, clock_hour, clock_minute, clock_second
//
// one request enters per cycle while the output is not stalled on m_tready
// the path is the three stage day split followed by the four stage date and clock units
// aresetn clears only the valid bits of the pipeline
// when the output waits on m_tready every stage holds and s_tready drops
module unix_time_to_calendar (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] epoch_seconds
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [11:0] cal_year, [15:12] cal_month, [20:16] cal_day,
                                   // [25:21] clock_hour, [31:26] clock_minute,
                                   // [37:32] clock_second, [39:38] zero
);

    logic                              en;
    logic [ut2c_pkg::LATENCY-1:0]      valid_reg;
    logic [ut2c_pkg::LATENCY-1:0]      valid_next;
    ut2c_pkg::split_t                  split;
    ut2c_pkg::tod_t                    tod;
    ut2c_pkg::date_t                   date;

    assign en       = !valid_reg[ut2c_pkg::LATENCY-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[ut2c_pkg::LATENCY-1];

    assign valid_next = {valid_reg[ut2c_pkg::LATENCY-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    ut2c_split u_split (
        .aclk          (aclk),
        .en            (en),
        .epoch_seconds (s_tdata),
        .split_out     (split)
    );

    ut2c_clock u_clock (
        .aclk    (aclk),
        .en      (en),
        .secs    (split.secs),
        .tod_out (tod)
    );

    ut2c_date u_date (
        .aclk     (aclk),
        .en       (en),
        .days     (split.days),
        .date_out (date)
    );

    assign m_tdata = {2'b00, tod.second, tod.minute, tod.hour,
                      date.day, date.month, date.year};

endmodule

>>> rtl/ut2c_split.sv
// splits the epoch count into whole days and seconds of the day, three stages
// depends on ut2c_pkg
module ut2c_split (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [31:0]          epoch_seconds,
    output ut2c_pkg::split_t     split_out
);

    // stage 1: reciprocal multiply of t / 128
    logic [50:0] prod_next;
    logic [15:0] q1_reg;
    logic [24:0] x1_reg;
    logic [6:0]  lo1_reg;

    assign prod_next = 51'(epoch_seconds[31:7]) * 51'(ut2c_pkg::DAY_RECIP);

    always_ff @(posedge aclk) begin
        if (en) begin
            q1_reg  <= prod_next[50:35];
            x1_reg  <= epoch_seconds[31:7];
            lo1_reg <= epoch_seconds[6:0];
        end
    end

    // stage 2: remainder of the estimate, below twice the divisor
    logic [25:0] back_mult;
    logic [24:0] diff;
    logic [10:0] rem2_next;
    logic [10:0] rem2_reg;
    logic [15:0] q2_reg;
    logic [6:0]  lo2_reg;

    assign back_mult = 26'(q1_reg) * 26'(ut2c_pkg::DAY_DIV);
    assign diff      = x1_reg - back_mult[24:0];
    assign rem2_next = diff[10:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem2_reg <= rem2_next;
            q2_reg   <= q1_reg;
            lo2_reg  <= lo1_reg;
        end
    end

    // stage 3: one step correction
    logic              corr;
    logic [10:0]       rem_fix;
    ut2c_pkg::split_t  split_next;
    ut2c_pkg::split_t  split_reg;

    always_comb begin
        corr            = (rem2_reg >= 11'(ut2c_pkg::DAY_DIV));
        rem_fix         = corr ? (rem2_reg - 11'(ut2c_pkg::DAY_DIV)) : rem2_reg;
        split_next.days = q2_reg + 16'(corr);
        split_next.secs = {rem_fix[9:0], lo2_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            split_reg <= split_next;
        end
    end

    assign split_out = split_reg;

endmodule

>>> rtl/ut2c_clock.sv
// hour, minute and second from the seconds of the day, four stages
// depends on ut2c_pkg
module ut2c_clock (
    input  logic             aclk,
    input  logic             en,
    input  logic [16:0]      secs,
    output ut2c_pkg::tod_t   tod_out
);

    // stage 1: hour estimate from secs / 16
    logic [25:0] hprod;
    logic [5:0]  qh1_reg;
    logic [12:0] xh1_reg;
    logic [3:0]  lo1_reg;

    assign hprod = 26'(secs[16:4]) * 26'(ut2c_pkg::HOUR_RECIP);

    always_ff @(posedge aclk) begin
        if (en) begin
            qh1_reg <= hprod[25:20];
            xh1_reg <= secs[16:4];
            lo1_reg <= secs[3:0];
        end
    end

    // stage 2: remainder of the hour estimate
    logic [13:0] hback;
    logic [12:0] hdiff;
    logic [8:0]  rh2_reg;
    logic [5:0]  qh2_reg;
    logic [3:0]  lo2_reg;

    assign hback = 14'(qh1_reg) * 14'(ut2c_pkg::HOUR_DIV);
    assign hdiff = xh1_reg - hback[12:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            rh2_reg <= hdiff[8:0];
            qh2_reg <= qh1_reg;
            lo2_reg <= lo1_reg;
        end
    end

    // stage 3: hour correction, then minute estimate from the rest / 4
    logic        hcorr;
    logic [8:0]  rh_fix;
    logic [11:0] rest_h;
    logic [20:0] mprod;
    logic [4:0]  hour3_reg;
    logic [5:0]  qm3_reg;
    logic [9:0]  xm3_reg;
    logic [1:0]  lo3_reg;

    always_comb begin
        hcorr  = (rh2_reg >= 9'(ut2c_pkg::HOUR_DIV));
        rh_fix = hcorr ? (rh2_reg - 9'(ut2c_pkg::HOUR_DIV)) : rh2_reg;
        rest_h = {rh_fix[7:0], lo2_reg};
        mprod  = 21'(rest_h[11:2]) * 21'(ut2c_pkg::MIN_RECIP);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hour3_reg <= 5'(qh2_reg + 6'(hcorr));
            qm3_reg   <= mprod[19:14];
            xm3_reg   <= rest_h[11:2];
            lo3_reg   <= rest_h[1:0];
        end
    end

    // stage 4: minute remainder with correction gives the second
    logic [9:0]      mback;
    logic [9:0]      mdiff;
    logic [4:0]      rm;
    logic            mcorr;
    logic [4:0]      rm_fix;
    ut2c_pkg::tod_t  tod_next;
    ut2c_pkg::tod_t  tod_reg;

    always_comb begin
        mback           = 10'(qm3_reg) * 10'(ut2c_pkg::MIN_DIV);
        mdiff           = xm3_reg - mback;
        rm              = mdiff[4:0];
        mcorr           = (rm >= 5'(ut2c_pkg::MIN_DIV));
        rm_fix          = mcorr ? (rm - 5'(ut2c_pkg::MIN_DIV)) : rm;
        tod_next.hour   = hour3_reg;
        tod_next.minute = qm3_reg + 6'(mcorr);
        tod_next.second = {rm_fix[3:0], lo3_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tod_reg <= tod_next;
        end
    end

    assign tod_out = tod_reg;

endmodule

>>> rtl/ut2c_date.sv
// year, month and day of month from the day count, four stages
// depends on ut2c_pkg
module ut2c_date (
    input  logic             aclk,
    input  logic             en,
    input  logic [15:0]      days,
    output ut2c_pkg::date_t  date_out
);

    // stage 1: rebase to 1968-01-01, skip feb 29 of 2100, estimate four year cycles
    logic [15:0] dd;
    logic [31:0] cprod;
    logic [15:0] dd1_reg;
    logic [5:0]  qc1_reg;

    always_comb begin
        dd    = days + ut2c_pkg::BASE_OFFSET + 16'(days >= ut2c_pkg::SKIP_DAY);
        cprod = 32'(dd) * 32'(ut2c_pkg::CYCLE_RECIP);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dd1_reg <= dd;
            qc1_reg <= cprod[31:26];
        end
    end

    // stage 2: remainder of the cycle estimate
    logic [16:0] cback;
    logic [15:0] cdiff;
    logic [11:0] rc2_reg;
    logic [5:0]  qc2_reg;

    assign cback = 17'(qc1_reg) * 17'(ut2c_pkg::CYCLE_DIV);
    assign cdiff = dd1_reg - cback[15:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            rc2_reg <= cdiff[11:0];
            qc2_reg <= qc1_reg;
        end
    end

    // stage 3: cycle correction, year within the cycle and day of year
    logic        ccorr;
    logic [5:0]  cyc;
    logic [10:0] rc_fix;
    logic [1:0]  yic;
    logic [10:0] yoff;
    logic [10:0] doy_full;
    logic [11:0] year3_reg;
    logic [8:0]  doy3_reg;
    logic        leap3_reg;

    always_comb begin
        ccorr  = (rc2_reg >= 12'(ut2c_pkg::CYCLE_DIV));
        cyc    = qc2_reg + 6'(ccorr);
        rc_fix = ccorr ? 11'(rc2_reg - 12'(ut2c_pkg::CYCLE_DIV)) : rc2_reg[10:0];
        if (rc_fix >= 11'd1096) begin
            yic  = 2'd3;
            yoff = 11'd1096;
        end else if (rc_fix >= 11'd731) begin
            yic  = 2'd2;
            yoff = 11'd731;
        end else if (rc_fix >= 11'd366) begin
            yic  = 2'd1;
            yoff = 11'd366;
        end else begin
            yic  = 2'd0;
            yoff = 11'd0;
        end
        doy_full = rc_fix - yoff;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            year3_reg <= ut2c_pkg::BASE_YEAR + 12'({cyc, 2'b00}) + 12'(yic);
            doy3_reg  <= doy_full[8:0];
            leap3_reg <= (yic == 2'd0);
        end
    end

    // stage 4: month by parallel compares against the month starts
    logic [3:0]       mcount;
    logic [3:0]       month;
    logic [8:0]       dom;
    ut2c_pkg::date_t  date_next;
    ut2c_pkg::date_t  date_reg;

    always_comb begin
        mcount = 4'd0;
        for (int m = 2; m <= 12; m++) begin
            if (doy3_reg >= ut2c_pkg::month_start(leap3_reg, 4'(m))) begin
                mcount = mcount + 4'd1;
            end
        end
        month           = mcount + 4'd1;
        dom             = doy3_reg - ut2c_pkg::month_start(leap3_reg, month) + 9'd1;
        date_next.year  = year3_reg;
        date_next.month = month;
        date_next.day   = dom[4:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            date_reg <= date_next;
        end
    end

    assign date_out = date_reg;

endmodule

>>> rtl/ut2c_checker.sv
// port level checks of the converter, bound to the top level
// depends on assert_macros.svh and unix_time_to_calendar
`include "assert_macros.svh"

module ut2c_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic        date_ok;
    logic        time_ok;

    assign out_year   = m_tdata[11:0];
    assign out_month  = m_tdata[15:12];
    assign out_day    = m_tdata[20:16];
    assign out_hour   = m_tdata[25:21];
    assign out_minute = m_tdata[31:26];
    assign out_second = m_tdata[37:32];

    assign date_ok = (out_month != 4'd0) && (out_month <= 4'd12) && (out_day != 5'd0) &&
                     (out_year >= 12'd1970) && (out_year <= 12'd2106);
    assign time_ok = (out_hour <= 5'd23) && (out_minute <= 6'd59) && (out_second <= 6'd59) &&
                     (m_tdata[39:38] == 2'b00);

    // a stalled result keeps its value
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // an empty output stage never blocks a request
    `ASSERT_CLK(a_ready_free, aclk, aresetn, !m_tvalid |-> s_tready)

    // date fields stay inside the calendar
    `ASSERT_CLK(a_date_range, aclk, aresetn, m_tvalid |-> date_ok)

    // time fields stay inside the day and the pad bits are zero
    `ASSERT_CLK(a_time_range, aclk, aresetn, m_tvalid |-> time_ok)

endmodule

bind unix_time_to_calendar ut2c_checker u_ut2c_checker (.*);

>>> bench/tb_unix_time_to_calendar.sv
// self-checking bench for unix_time_to_calendar: a directed table, then random requests,
// each result checked field by field against a typed value or a calendar predictor
// depends on ut2c_pkg (latency) and the rtl of unix_time_to_calendar
module tb_unix_time_to_calendar;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SECONDS_PER_DAY    = 86400;
    localparam int unsigned SECONDS_PER_HOUR   = 3600;
    localparam int unsigned SECONDS_PER_MINUTE = 60;
    localparam int unsigned EPOCH_YEAR         = 1970;
    localparam int unsigned LAST_YEAR          = 2106;

    localparam int TABLE_ROWS      = 22;
    localparam int RANDOM_REQUESTS = 1028;
    localparam int FLOOD_AT        = 400;
    localparam int FLOOD_REQUESTS  = 48;
    localparam int DRAIN_AT        = 700;
    localparam int HOLD_CYCLES     = 64;
    localparam int CYCLE_LIMIT     = 200000;

    // same layout as m_tdata[37:0], year in the low bits
    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } cal_t;

    typedef struct {
        logic [31:0] epoch;
        bit          typed;
        cal_t        want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    cal_t        expected_q [$];
    stim_row_t   directed_rows [TABLE_ROWS];
    int          error_count  = 0;
    int          results_seen = 0;
    int          cycle_count  = 0;
    int unsigned burst_left   = 0;
    bit          hold_request = 1'b0;
    bit          hold_done    = 1'b0;

    unix_time_to_calendar dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic bit is_leap(input int unsigned year);
        return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    endfunction

    function automatic int unsigned year_len(input int unsigned year);
        return is_leap(year) ? 366 : 365;
    endfunction

    function automatic int unsigned month_len(input int unsigned year, input int unsigned month);
        case (month)
            2:           return is_leap(year) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic cal_t calendar(input int unsigned year, input int unsigned month,
                                      input int unsigned day, input int unsigned hour,
                                      input int unsigned minute, input int unsigned second);
        cal_t c;
        c.year   = 12'(year);
        c.month  = 4'(month);
        c.day    = 5'(day);
        c.hour   = 5'(hour);
        c.minute = 6'(minute);
        c.second = 6'(second);
        return c;
    endfunction

    // whole years first, then whole months of that year, remainder is the day
    function automatic cal_t calendar_of(input logic [31:0] epoch);
        int unsigned days;
        int unsigned secs;
        int unsigned year;
        int unsigned month;
        days  = epoch / SECONDS_PER_DAY;
        secs  = epoch % SECONDS_PER_DAY;
        year  = EPOCH_YEAR;
        month = 1;
        while (days >= year_len(year)) begin
            days -= year_len(year);
            year++;
        end
        while (month < 12 && days >= month_len(year, month)) begin
            days -= month_len(year, month);
            month++;
        end
        return calendar(year, month, days + 1, secs / SECONDS_PER_HOUR,
                        (secs % SECONDS_PER_HOUR) / SECONDS_PER_MINUTE,
                        secs % SECONDS_PER_MINUTE);
    endfunction

    // midnight of a date, may run past 32 bits in 2106
    function automatic longint unsigned epoch_of(input int unsigned year,
                                                 input int unsigned month,
                                                 input int unsigned day);
        longint unsigned days;
        int unsigned     y;
        int unsigned     m;
        days = 0;
        for (y = EPOCH_YEAR; y < year; y++)
            days += year_len(y);
        for (m = 1; m < month; m++)
            days += month_len(year, m);
        return (days + day - 1) * SECONDS_PER_DAY;
    endfunction

    // mix of raw values, values around month and year boundaries, and both ends of the range
    function automatic logic [31:0] pick_epoch();
        int unsigned kind;
        int unsigned day;
        kind = $urandom_range(0, 9);
        day  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 28) : 1;
        if (kind < 5)
            return $urandom;
        if (kind < 8)
            return 32'(epoch_of($urandom_range(EPOCH_YEAR, LAST_YEAR), $urandom_range(1, 12),
                                day) + $urandom_range(0, 4) - 2);
        if (kind == 8)
            return $urandom_range(0, 200000000);
        return 32'hFFFF_FFFF - $urandom_range(0, 50000000);
    endfunction

    task automatic report_failure(input string what);
        $display("error at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // offer one request and hold it until accepted
    task automatic send_request(input logic [31:0] epoch, input cal_t want);
        s_tvalid <= 1'b1;
        s_tdata  <= epoch;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        expected_q.push_back(want);
    endtask

    // bursts of random length, idle gaps between them carry junk data
    task automatic pace();
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= $urandom;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_q.size() != 0)
            @(posedge aclk);
    endtask

    initial begin : stimulus
        cal_t want;
        int   n;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;

        directed_rows[0]  = '{32'd0,          1'b1, calendar(1970, 1, 1, 0, 0, 0)};
        directed_rows[1]  = '{32'hFFFF_FFFF,  1'b1, calendar(2106, 2, 7, 6, 28, 15)};
        directed_rows[2]  = '{32'd59,         1'b1, calendar(1970, 1, 1, 0, 0, 59)};
        directed_rows[3]  = '{32'd86399,      1'b1, calendar(1970, 1, 1, 23, 59, 59)};
        directed_rows[4]  = '{32'd86400,      1'b1, calendar(1970, 1, 2, 0, 0, 0)};
        // year and month edges, leap day of 1972 and 2000, 2100 without one
        directed_rows[5]  = '{32'd31535999,   1'b0, cal_t'(0)};
        directed_rows[6]  = '{32'd31536000,   1'b0, cal_t'(0)};
        directed_rows[7]  = '{32'd68169600,   1'b0, cal_t'(0)};
        directed_rows[8]  = '{32'd946684799,  1'b0, cal_t'(0)};
        directed_rows[9]  = '{32'd946684800,  1'b0, cal_t'(0)};
        directed_rows[10] = '{32'd951782399,  1'b0, cal_t'(0)};
        directed_rows[11] = '{32'd951782400,  1'b0, cal_t'(0)};
        directed_rows[12] = '{32'd951868800,  1'b0, cal_t'(0)};
        directed_rows[13] = '{32'd4102444800, 1'b0, cal_t'(0)};
        directed_rows[14] = '{32'd4107542399, 1'b0, cal_t'(0)};
        directed_rows[15] = '{32'd4107542400, 1'b0, cal_t'(0)};
        directed_rows[16] = '{32'd4133980799, 1'b0, cal_t'(0)};
        directed_rows[17] = '{32'd2147483647, 1'b0, cal_t'(0)};
        directed_rows[18] = '{32'd2147483648, 1'b0, cal_t'(0)};
        directed_rows[19] = '{32'hAAAA_AAAA,  1'b0, cal_t'(0)};
        directed_rows[20] = '{32'h5555_5555,  1'b0, cal_t'(0)};
        directed_rows[21] = '{32'hFFFF_FFFE,  1'b0, cal_t'(0)};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (n = 0; n < TABLE_ROWS; n++) begin
            want = directed_rows[n].typed ? directed_rows[n].want
                                          : calendar_of(directed_rows[n].epoch);
            send_request(directed_rows[n].epoch, want);
            pace();
        end
        drain();

        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            logic [31:0] epoch;
            epoch = pick_epoch();
            // back to back requests while the receiver holds off, so the input stalls
            if (n == FLOOD_AT)
                hold_request = 1'b1;
            if (n == DRAIN_AT)
                drain();
            send_request(epoch, calendar_of(epoch));
            if (n < FLOOD_AT || n >= FLOOD_AT + FLOOD_REQUESTS)
                pace();
        end

        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (4 * ut2c_pkg::LATENCY) @(posedge aclk);
        if (error_count == 0)
            $display("unix_time_to_calendar verification clean");
        else
            $display("unix_time_to_calendar verification failed");
        $finish;
    end

    // receiver: segments of always ready, mostly ready, mostly stalled and a square wave
    initial begin : receiver
        int unsigned mode;
        int unsigned span;
        int unsigned k;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 64);
                for (k = 0; k < span && !(hold_request && !hold_done); k++) begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= ($urandom_range(0, 3) != 0);
                        2:       m_tready <= ($urandom_range(0, 3) == 0);
                        default: m_tready <= k[2];
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin : result_check
        cal_t got;
        cal_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready) begin
            got = cal_t'(m_tdata[37:0]);
            if (expected_q.size() == 0) begin
                report_failure($sformatf("result %0d with no request pending: %h",
                                         results_seen, m_tdata));
            end else begin
                want = expected_q.pop_front();
                if (got.year != want.year)
                    report_failure($sformatf("result %0d year %0d, expected %0d",
                                             results_seen, got.year, want.year));
                if (got.month != want.month)
                    report_failure($sformatf("result %0d month %0d, expected %0d",
                                             results_seen, got.month, want.month));
                if (got.day != want.day)
                    report_failure($sformatf("result %0d day %0d, expected %0d",
                                             results_seen, got.day, want.day));
                if (got.hour != want.hour)
                    report_failure($sformatf("result %0d hour %0d, expected %0d",
                                             results_seen, got.hour, want.hour));
                if (got.minute != want.minute)
                    report_failure($sformatf("result %0d minute %0d, expected %0d",
                                             results_seen, got.minute, want.minute));
                if (got.second != want.second)
                    report_failure($sformatf("result %0d second %0d, expected %0d",
                                             results_seen, got.second, want.second));
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("unix_time_to_calendar verification failed");
            $finish;
        end
    end

endmodule
